// ----- src/fjhs_pkg.sv -----
// feeder jam and heat supervisor: shared widths, register indexes and reset values
// no dependencies
`default_nettype none

package fjhs_pkg;

    // field widths
    localparam int unsigned SpeedW  = 15;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned AngleW  = 32;
    localparam int unsigned Cfg16W  = 16;
    localparam int unsigned LimitW  = 31;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = LimitW;

    // packed word widths, padded to whole bytes
    localparam int unsigned InFieldW  = TimeW + AngleW + 1;
    localparam int unsigned InDataW   = ((InFieldW + 7) / 8) * 8;
    localparam int unsigned OutFieldW = SpeedW + 3;
    localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_FORWARD_SPEED   = 3'd0,
        CFG_REVERSE_SPEED   = 3'd1,
        CFG_CHECK_INTERVAL  = 3'd2,
        CFG_REVERSE_TIME    = 3'd3,
        CFG_STALL_THRESHOLD = 3'd4,
        CFG_HEAT_LIMIT      = 3'd5
    } t_cfg_idx;

    // register values after reset
    localparam logic signed [SpeedW-1:0] ForwardSpeedRst  = -15'sd2500;
    localparam logic signed [SpeedW-1:0] ReverseSpeedRst  = 15'sd1000;
    localparam logic [Cfg16W-1:0]        CheckIntervalRst = 16'd800;
    localparam logic [Cfg16W-1:0]        ReverseTimeRst   = 16'd500;
    localparam logic [Cfg16W-1:0]        StallThreshRst   = 16'd20;
    localparam logic [LimitW-1:0]        HeatLimitRst     = 31'd1800000;

endpackage

`default_nettype wire

// ----- src/feeder_jam_and_heat_supervisor_top.sv -----
// feeder jam and heat supervisor, top level
// depends on fjhs_pkg
`default_nettype none

// One input word per control tick (time in ms, total motor angle, fire enable)
// gives exactly one output word (speed setpoint, reversing, overheated,
// jam_started). The block takes one word per clock cycle when the output side
// keeps up; a word passes through the input register, then the result
// register, before its result is offered. Both registers are separately
// held, so a new word is still taken into an empty input register while a
// finished result waits for the sink. The per-tick work is three 32/33-bit
// subtract-and-compare paths (reverse timer, check interval, angle movement)
// plus the heat difference, all between the input register and the result
// register; supervisor state updates on the same edge as the result register.
// Configuration registers are to be written through the plain write port only
// while the block is idle (the block itself does not enforce this) and take
// effect for the next word; unknown indexes are ignored.
module feeder_jam_and_heat_supervisor_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // config write port
    input  wire                               i_cfg_we,
    input  wire [fjhs_pkg::CfgIdxW-1:0]       i_cfg_addr,
    input  wire [fjhs_pkg::CfgDataW-1:0]      i_cfg_wdata,
    // input words
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // now_ms [31:0], total_angle [63:32], fire_enable [64], zero pad [71:65]
    input  wire [fjhs_pkg::InDataW-1:0]       s_axis_tdata,
    // result words
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // speed_setpoint [14:0], reversing [15], overheated [16],
    // jam_started [17], zero pad [23:18]
    output logic [fjhs_pkg::OutDataW-1:0]     m_axis_tdata
);

    localparam int unsigned SpW = fjhs_pkg::SpeedW;
    localparam int unsigned TmW = fjhs_pkg::TimeW;
    localparam int unsigned AnW = fjhs_pkg::AngleW;
    localparam int unsigned C16 = fjhs_pkg::Cfg16W;
    localparam int unsigned LmW = fjhs_pkg::LimitW;

    // configuration registers
    logic signed [SpW-1:0] r_forward_speed;
    logic signed [SpW-1:0] r_reverse_speed;
    logic [C16-1:0]        r_check_interval;
    logic [C16-1:0]        r_reverse_time;
    logic [C16-1:0]        r_stall_thresh;
    logic [LmW-1:0]        r_heat_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward_speed  <= fjhs_pkg::ForwardSpeedRst;
            r_reverse_speed  <= fjhs_pkg::ReverseSpeedRst;
            r_check_interval <= fjhs_pkg::CheckIntervalRst;
            r_reverse_time   <= fjhs_pkg::ReverseTimeRst;
            r_stall_thresh   <= fjhs_pkg::StallThreshRst;
            r_heat_limit     <= fjhs_pkg::HeatLimitRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fjhs_pkg::CFG_FORWARD_SPEED:   r_forward_speed  <= i_cfg_wdata[SpW-1:0];
                fjhs_pkg::CFG_REVERSE_SPEED:   r_reverse_speed  <= i_cfg_wdata[SpW-1:0];
                fjhs_pkg::CFG_CHECK_INTERVAL:  r_check_interval <= i_cfg_wdata[C16-1:0];
                fjhs_pkg::CFG_REVERSE_TIME:    r_reverse_time   <= i_cfg_wdata[C16-1:0];
                fjhs_pkg::CFG_STALL_THRESHOLD: r_stall_thresh   <= i_cfg_wdata[C16-1:0];
                fjhs_pkg::CFG_HEAT_LIMIT:      r_heat_limit     <= i_cfg_wdata[LmW-1:0];
                default: ;
            endcase
        end
    end

    // handshake: result register moves when empty or taken, input register
    // moves when empty or its word passes into the result register
    logic r_in_valid;
    logic r_out_valid;
    logic w_advance;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;

    // input register
    logic [TmW-1:0] r_now;
    logic [AnW-1:0] r_angle;
    logic           r_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_now   <= s_axis_tdata[TmW-1:0];
            r_angle <= s_axis_tdata[TmW+AnW-1:TmW];
            r_fire  <= s_axis_tdata[TmW+AnW];
        end
    end

    // supervisor state
    logic           r_reverse_active;
    logic [TmW-1:0] r_reverse_start;
    logic [TmW-1:0] r_last_check;
    logic [AnW-1:0] r_check_angle;
    logic           r_heat_latch;
    logic [AnW-1:0] r_entry_angle;
    logic           r_entry_valid;

    logic           n_reverse_active;
    logic [TmW-1:0] n_reverse_start;
    logic [TmW-1:0] n_last_check;
    logic [AnW-1:0] n_check_angle;
    logic           n_heat_latch;
    logic [AnW-1:0] n_entry_angle;
    logic           n_entry_valid;
    logic signed [SpW-1:0] n_speed;
    logic           n_jam;

    // datapath terms, all taken modulo 2^32 for time
    logic [TmW-1:0]       w_rev_elapsed;
    logic [TmW-1:0]       w_chk_elapsed;
    logic                 w_rev_hold;
    logic                 w_check_due;
    logic signed [AnW:0]  w_move;
    logic [AnW:0]         w_move_abs;
    logic                 w_stall;
    logic signed [AnW:0]  w_heat;
    logic                 w_heat_over;

    assign w_rev_elapsed = r_now - r_reverse_start;
    assign w_chk_elapsed = r_now - r_last_check;
    assign w_rev_hold    = r_reverse_active
                           && (w_rev_elapsed < {{(TmW-C16){1'b0}}, r_reverse_time});
    assign w_check_due   = w_chk_elapsed >= {{(TmW-C16){1'b0}}, r_check_interval};

    // exact 33-bit angle movement since the last check point
    assign w_move     = $signed({r_angle[AnW-1], r_angle})
                        - $signed({r_check_angle[AnW-1], r_check_angle});
    assign w_move_abs = w_move[AnW] ? (~w_move + 1'b1) : w_move;
    assign w_stall    = (w_move_abs < {{(AnW+1-C16){1'b0}}, r_stall_thresh}) && !r_heat_latch;

    // heat is zero on the first firing tick
    assign w_heat      = r_entry_valid
                         ? ($signed({r_entry_angle[AnW-1], r_entry_angle})
                            - $signed({r_angle[AnW-1], r_angle}))
                         : '0;
    assign w_heat_over = $signed({w_heat[AnW], w_heat})
                         >= $signed({{(AnW+2-LmW){1'b0}}, r_heat_limit});

    always_comb begin
        n_reverse_active = r_reverse_active;
        n_reverse_start  = r_reverse_start;
        n_last_check     = r_last_check;
        n_check_angle    = r_check_angle;
        n_heat_latch     = r_heat_latch;
        n_entry_angle    = r_entry_angle;
        n_entry_valid    = r_entry_valid;
        n_speed          = '0;
        n_jam            = 1'b0;
        if (w_rev_hold) begin
            // reverse still running: hold everything else
            n_speed = r_reverse_speed;
        end else begin
            n_reverse_active = 1'b0;
            if (r_fire) begin
                n_speed = r_heat_latch ? '0 : r_forward_speed;
                if (w_check_due) begin
                    if (w_stall) begin
                        n_reverse_active = 1'b1;
                        n_reverse_start  = r_now;
                        n_speed          = r_reverse_speed;
                        n_jam            = 1'b1;
                    end
                    n_last_check  = r_now;
                    n_check_angle = r_angle;
                end
                if (!r_entry_valid) begin
                    n_entry_angle = r_angle;
                    n_entry_valid = 1'b1;
                end
                if (w_heat_over) begin
                    n_heat_latch = 1'b1;
                end
            end else begin
                // fire released: drop latch and entry point, keep check point
                n_heat_latch  = 1'b0;
                n_entry_angle = '0;
                n_entry_valid = 1'b0;
            end
        end
    end

    logic w_step;
    assign w_step = r_in_valid && w_advance;

    // result register
    logic signed [SpW-1:0] r_speed;
    logic                  r_reversing;
    logic                  r_overheated;
    logic                  r_jam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_reverse_active <= 1'b0;
            r_reverse_start  <= '0;
            r_last_check     <= '0;
            r_check_angle    <= '0;
            r_heat_latch     <= 1'b0;
            r_entry_angle    <= '0;
            r_entry_valid    <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_reverse_active <= n_reverse_active;
                r_reverse_start  <= n_reverse_start;
                r_last_check     <= n_last_check;
                r_check_angle    <= n_check_angle;
                r_heat_latch     <= n_heat_latch;
                r_entry_angle    <= n_entry_angle;
                r_entry_valid    <= n_entry_valid;
            end
        end
        if (w_step) begin
            r_speed      <= n_speed;
            r_reversing  <= n_reverse_active;
            r_overheated <= n_heat_latch;
            r_jam        <= n_jam;
        end
    end

    assign m_axis_tdata = {{(fjhs_pkg::OutDataW-fjhs_pkg::OutFieldW){1'b0}},
                           r_jam, r_overheated, r_reversing, r_speed};

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking bench for feeder_jam_and_heat_supervisor_top: directed ticks, then random runs
// depends on fjhs_pkg and the top level in src
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CycleLimit     = 400000;
    localparam int unsigned WordsPerPhase  = 215;
    localparam int unsigned NumPhases      = 6;
    localparam int unsigned PressureAt     = 100;   // results seen before the long sink hold-off
    localparam int unsigned PressureCycles = 300;
    localparam int unsigned DrainCycles    = 8;     // two-stage pipe, plenty of margin
    localparam int unsigned MaxPrinted     = 100;
    localparam int unsigned NumRows        = 18;

    // one result word, fields by name
    typedef struct packed {
        logic signed [fjhs_pkg::SpeedW-1:0] speed;
        logic                               reversing;
        logic                               overheated;
        logic                               jam;
    } t_tick_result;

    // one row of the directed table; want is only used where typed is set
    typedef struct packed {
        logic [fjhs_pkg::TimeW-1:0]  now_ms;
        logic [fjhs_pkg::AngleW-1:0] angle;
        logic                        fire;
        logic                        typed;
        t_tick_result                want;
    } t_tick_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [fjhs_pkg::CfgIdxW-1:0]  i_cfg_addr = '0;
    logic [fjhs_pkg::CfgDataW-1:0] i_cfg_wdata = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [fjhs_pkg::InDataW-1:0]  s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [fjhs_pkg::OutDataW-1:0] m_axis_tdata;

    // supervisor copy: settings
    logic signed [fjhs_pkg::SpeedW-1:0] cfg_fwd_speed  = fjhs_pkg::ForwardSpeedRst;
    logic signed [fjhs_pkg::SpeedW-1:0] cfg_rev_speed  = fjhs_pkg::ReverseSpeedRst;
    logic [fjhs_pkg::Cfg16W-1:0]        cfg_check_ms   = fjhs_pkg::CheckIntervalRst;
    logic [fjhs_pkg::Cfg16W-1:0]        cfg_rev_ms     = fjhs_pkg::ReverseTimeRst;
    logic [fjhs_pkg::Cfg16W-1:0]        cfg_stall_min  = fjhs_pkg::StallThreshRst;
    logic [fjhs_pkg::LimitW-1:0]        cfg_heat_limit = fjhs_pkg::HeatLimitRst;

    // supervisor copy: state
    logic                        rev_active    = 1'b0;
    logic [fjhs_pkg::TimeW-1:0]  rev_start_ms  = '0;
    logic [fjhs_pkg::TimeW-1:0]  last_check_ms = '0;
    logic [fjhs_pkg::AngleW-1:0] check_ang     = '0;
    logic                        heat_latched  = 1'b0;
    logic [fjhs_pkg::AngleW-1:0] entry_ang     = '0;
    logic                        entry_ok      = 1'b0;

    t_tick_result pending_results[$];
    int unsigned  results_seen  = 0;
    int unsigned  mismatches    = 0;
    int unsigned  cycle_count   = 0;
    int unsigned  src_idle_pct  = 26;
    int unsigned  sink_idle_pct = 55;
    logic         pressure_done = 1'b0;

    feeder_jam_and_heat_supervisor_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // now_ms [31:0], total_angle [63:32], fire_enable [64], zero pad [71:65]
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // speed_setpoint [14:0], reversing [15], overheated [16], jam_started [17], pad [23:18]
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // one control tick of the supervisor: updates the local state, returns the result word
    function automatic t_tick_result feeder_tick(input logic [fjhs_pkg::TimeW-1:0] now_ms,
                                                 input logic [fjhs_pkg::AngleW-1:0] angle,
                                                 input logic fire);
        t_tick_result               r;
        logic [fjhs_pkg::TimeW-1:0] since;
        logic signed [32:0]         move;
        logic signed [32:0]         heat;
        r = '0;
        // a running reverse swallows the tick until its time is up
        if (rev_active) begin
            since = now_ms - rev_start_ms;
            if (since >= {16'd0, cfg_rev_ms}) begin
                rev_active = 1'b0;
            end else begin
                r.speed      = cfg_rev_speed;
                r.reversing  = 1'b1;
                r.overheated = heat_latched;
                return r;
            end
        end
        if (fire) begin
            // setpoint judged on the latch before this tick's heat update
            r.speed = heat_latched ? '0 : cfg_fwd_speed;
            since = now_ms - last_check_ms;
            if (since >= {16'd0, cfg_check_ms}) begin
                // exact 33-bit movement, never overflows
                move = {angle[31], angle} - {check_ang[31], check_ang};
                if (move < 0) move = -move;
                if (move < $signed({17'd0, cfg_stall_min}) && !heat_latched) begin
                    rev_active   = 1'b1;
                    rev_start_ms = now_ms;
                    r.speed      = cfg_rev_speed;
                    r.jam        = 1'b1;
                end
                last_check_ms = now_ms;
                check_ang     = angle;
            end
            // first firing tick takes the entry angle and counts no heat
            if (!entry_ok) begin
                entry_ang = angle;
                entry_ok  = 1'b1;
                heat      = '0;
            end else begin
                heat = {entry_ang[31], entry_ang} - {angle[31], angle};
            end
            if (heat >= $signed({2'b00, cfg_heat_limit})) heat_latched = 1'b1;
        end else begin
            // fire released: latch and entry cleared, stall check points kept
            r.speed      = '0;
            heat_latched = 1'b0;
            entry_ang    = '0;
            entry_ok     = 1'b0;
        end
        r.reversing  = rev_active;
        r.overheated = heat_latched;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < MaxPrinted)
            $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    // register write; the caller lowers the write enable after its last write
    task automatic write_reg(input fjhs_pkg::t_cfg_idx idx,
                             input logic [fjhs_pkg::CfgDataW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            fjhs_pkg::CFG_FORWARD_SPEED:   cfg_fwd_speed  = value[fjhs_pkg::SpeedW-1:0];
            fjhs_pkg::CFG_REVERSE_SPEED:   cfg_rev_speed  = value[fjhs_pkg::SpeedW-1:0];
            fjhs_pkg::CFG_CHECK_INTERVAL:  cfg_check_ms   = value[fjhs_pkg::Cfg16W-1:0];
            fjhs_pkg::CFG_REVERSE_TIME:    cfg_rev_ms     = value[fjhs_pkg::Cfg16W-1:0];
            fjhs_pkg::CFG_STALL_THRESHOLD: cfg_stall_min  = value[fjhs_pkg::Cfg16W-1:0];
            fjhs_pkg::CFG_HEAT_LIMIT:      cfg_heat_limit = value[fjhs_pkg::LimitW-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic signed [fjhs_pkg::SpeedW-1:0] fwd,
                                 input logic signed [fjhs_pkg::SpeedW-1:0] rev,
                                 input logic [fjhs_pkg::Cfg16W-1:0] check_ms,
                                 input logic [fjhs_pkg::Cfg16W-1:0] rev_ms,
                                 input logic [fjhs_pkg::Cfg16W-1:0] stall_min,
                                 input logic [fjhs_pkg::LimitW-1:0] heat_limit);
        write_reg(fjhs_pkg::CFG_FORWARD_SPEED,   {16'd0, fwd});
        write_reg(fjhs_pkg::CFG_REVERSE_SPEED,   {16'd0, rev});
        write_reg(fjhs_pkg::CFG_CHECK_INTERVAL,  {15'd0, check_ms});
        write_reg(fjhs_pkg::CFG_REVERSE_TIME,    {15'd0, rev_ms});
        write_reg(fjhs_pkg::CFG_STALL_THRESHOLD, {15'd0, stall_min});
        write_reg(fjhs_pkg::CFG_HEAT_LIMIT,      heat_limit);
        i_cfg_we <= 1'b0;
    endtask

    // offer one tick word, with random gaps ahead of it; valid stays up for the next word
    task automatic send_tick(input logic [fjhs_pkg::TimeW-1:0] now_ms,
                             input logic [fjhs_pkg::AngleW-1:0] angle,
                             input logic fire, input logic typed, input t_tick_result want);
        t_tick_result predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, fire, angle, now_ms};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = feeder_tick(now_ms, angle, fire);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // drop valid and wait until every result is in and the pipe is quiet
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // result side: checks each accepted word, drives tready, one long hold-off for back-pressure
    initial begin : result_sink
        int unsigned  hold_left;
        t_tick_result got;
        t_tick_result want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.speed      = m_axis_tdata[14:0];
                got.reversing  = m_axis_tdata[15];
                got.overheated = m_axis_tdata[16];
                got.jam        = m_axis_tdata[17];
                if (pending_results.size() == 0) begin
                    flag_mismatch("word with none expected", int'(got.speed), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.speed !== want.speed)
                        flag_mismatch("speed_setpoint", int'(got.speed), int'(want.speed));
                    if (got.reversing !== want.reversing)
                        flag_mismatch("reversing", int'(got.reversing), int'(want.reversing));
                    if (got.overheated !== want.overheated)
                        flag_mismatch("overheated", int'(got.overheated), int'(want.overheated));
                    if (got.jam !== want.jam)
                        flag_mismatch("jam_started", int'(got.jam), int'(want.jam));
                end
                results_seen++;
            end
            // long stall so the block fills and pushes back on its input
            if (!pressure_done && results_seen >= PressureAt) begin
                hold_left     = PressureCycles;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("feeder_jam_and_heat_supervisor_top: mismatch");
        $finish;
    end

    initial begin : tick_source
        t_tick_row                   rows [NumRows];
        t_tick_result                none;
        logic [fjhs_pkg::TimeW-1:0]  now_ms;
        logic [fjhs_pkg::AngleW-1:0] angle;
        logic                        fire;
        logic                        stalled;
        int unsigned                 fire_left;
        int unsigned                 motion_left;
        int unsigned                 tstep_max;
        int unsigned                 step;

        none = '0;
        // reset settings throughout; typed rows are the obvious ones
        rows = '{
            // after reset, fire off
            '{32'd0, 32'd0, 1'b0, 1'b1, '{15'sd0, 1'b0, 1'b0, 1'b0}},
            // first firing tick, no check due yet
            '{32'd10, 32'd100, 1'b1, 1'b1, '{fjhs_pkg::ForwardSpeedRst, 1'b0, 1'b0, 1'b0}},
            // check due, plenty of movement
            '{32'd800, 32'd105, 1'b1, 1'b0, '0},
            // check due, stalled: reverse starts
            '{32'd1600, 32'd110, 1'b1, 1'b0, '0},
            // reverse running, fire off ignored
            '{32'd1700, 32'd110, 1'b0, 1'b0, '0},
            // reverse ends exactly on time, big travel latches overheat
            '{32'd2100, -32'sd2000000, 1'b1, 1'b0, '0},
            '{32'd2400, -32'sd2000000, 1'b1, 1'b0, '0},
            // stall while overheated starts no reverse
            '{32'd3200, -32'sd2000000, 1'b1, 1'b0, '0},
            // fire released clears the latch
            '{32'd3300, -32'sd2000000, 1'b0, 1'b1, '{15'sd0, 1'b0, 1'b0, 1'b0}},
            // angle extremes, full 33-bit heat
            '{32'd3350, 32'h7FFF_FFFF, 1'b1, 1'b0, '0},
            '{32'd4000, 32'h8000_0000, 1'b1, 1'b0, '0},
            '{32'd4001, 32'h8000_0000, 1'b0, 1'b1, '{15'sd0, 1'b0, 1'b0, 1'b0}},
            // time wrap around the check and the reverse timer
            '{32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0, '0},
            '{32'h0000_031F, 32'd5, 1'b1, 1'b0, '0},
            '{32'h0000_0512, 32'd5, 1'b1, 1'b0, '0},
            '{32'h0000_0513, 32'd5, 1'b1, 1'b0, '0},
            '{32'h0000_0833, 32'd5, 1'b1, 1'b0, '0},
            '{32'h0000_0834, 32'd5, 1'b0, 1'b0, '0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NumRows; k++)
            send_tick(rows[k].now_ms, rows[k].angle, rows[k].fire, rows[k].typed, rows[k].want);

        now_ms      = $urandom;
        angle       = $urandom;
        fire        = 1'b1;
        fire_left   = 0;
        motion_left = 0;
        stalled     = 1'b0;

        for (int p = 0; p < NumPhases; p++) begin
            drain_block();
            // sender and receiver busy/idle split changes every two phases
            case (p / 2)
                0: begin src_idle_pct = 26; sink_idle_pct = 55; end
                1: begin src_idle_pct = 55; sink_idle_pct = 26; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            case (p)
                // bottom of every range: check every tick, no stalls, instant overheat
                1: load_settings(-15'sd16384, 15'sd16383, 16'd0, 16'd0, 16'd0, 31'd0);
                // top of every range: highest stall threshold, long reverses, highest heat limit
                2: load_settings(15'sd16383, -15'sd16384, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 31'h7FFF_FFFF);
                // check on every firing tick with the highest stall threshold, short reverses
                4: load_settings(15'($urandom), 15'($urandom), 16'd0,
                                 16'($urandom_range(0, 40)), 16'hFFFF,
                                 31'($urandom_range(2000, 60000)));
                default: load_settings(15'($urandom), 15'($urandom),
                                       16'($urandom_range(20, 400)),
                                       16'($urandom_range(0, 300)),
                                       16'($urandom_range(0, 500)),
                                       31'($urandom_range(2000, 200000)));
            endcase
            tstep_max = ((cfg_check_ms > cfg_rev_ms) ? cfg_check_ms : cfg_rev_ms) / 3 + 4;

            for (int n = 0; n < WordsPerPhase; n++) begin
                // firing runs with short releases in between
                if (fire_left == 0) begin
                    fire      = ($urandom_range(0, 99) < 12) ? 1'b0 : 1'b1;
                    fire_left = fire ? $urandom_range(5, 60) : $urandom_range(1, 4);
                end
                fire_left--;
                // motion runs: either near-stalled or moving, mostly backwards to build heat
                if (motion_left == 0) begin
                    stalled     = ($urandom_range(0, 99) < 35);
                    motion_left = $urandom_range(3, 30);
                end
                motion_left--;
                if ($urandom_range(0, 99) < 3) begin
                    now_ms = $urandom;
                end else begin
                    now_ms = now_ms + $urandom_range(0, tstep_max);
                end
                if ($urandom_range(0, 99) < 3) begin
                    angle = $urandom;
                end else if (stalled) begin
                    angle = angle + $urandom_range(0, 2) - 1;
                end else begin
                    step  = $urandom_range(0, 2500);
                    angle = ($urandom_range(0, 3) == 0) ? angle + step : angle - step;
                end
                send_tick(now_ms, angle, fire, 1'b0, none);
            end
        end

        drain_block();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("feeder_jam_and_heat_supervisor_top: match");
        end else begin
            $display("feeder_jam_and_heat_supervisor_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/fjhs_pkg.sv
src/feeder_jam_and_heat_supervisor_top.sv
test/tb_top.sv
